@@ sv/lpp_pkg.sv @@
// Package for the LRU page pool with pinning.
// Holds the request and status codes, the cell entry, command and flag types,
// and the controller state type. It depends on nothing else.
package lpp_pkg;

  localparam logic [1:0] FUNC_NEW = 2'd0;
  localparam logic [1:0] FUNC_GET = 2'd1;
  localparam logic [1:0] FUNC_REL = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_BAD_ID   = 2'd1;
  localparam logic [1:0] STS_UNPINNED = 2'd2;
  localparam logic [1:0] STS_NO_FRAME = 2'd3;

  localparam logic [4:0] CAP_FLOOR = 5'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_EVICT_PUSH,
    OP_MOVE,
    OP_UNPIN
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [7:0] id;
    logic       valid;
    logic       pin;
  } entry_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] key;
    logic [7:0] id;
  } cmd_t;

  typedef struct packed {
    logic       any_hit;
    logic       hit_pin;
    logic       any_free;
    logic [7:0] victim_id;
  } summary_t;

endpackage

@@ sv/lpp_if.sv @@
// Channel interfaces for the LRU page pool: request words in, response words out.
// Each carries valid, ready and its payload. Depends on nothing else.
interface lpp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] page_id;

  modport source (output valid, func, page_id, input ready);
  modport sink (input valid, func, page_id, output ready);
endinterface

interface lpp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] assigned_page;
  logic       load_needed;
  logic       evict_valid;
  logic [7:0] evicted_page;
  logic [4:0] capacity_now;

  modport source (output valid, status, assigned_page, load_needed, evict_valid,
                  evicted_page, capacity_now, input ready);
  modport sink (input valid, status, assigned_page, load_needed, evict_valid,
                evicted_page, capacity_now, output ready);
endinterface

@@ sv/lpp_cell.sv @@
// One slot of the recency chain: a page id, a valid bit and a pin bit.
// Uses lpp_pkg; shifts in from its front neighbor under the controller's command.
module lpp_cell (
  input  logic            clk,
  input  logic            rst,
  input  lpp_pkg::cmd_t   cmd,
  input  lpp_pkg::entry_t left,
  output lpp_pkg::entry_t ent,
  input  logic            hit_before_in,
  output logic            hit_before_out,
  input  logic            free_after_in,
  output logic            free_after_out,
  output logic            hit,
  output logic            victim
);
  import lpp_pkg::*;

  logic free;
  logic take_left;

  assign hit            = ent.valid && (ent.id == cmd.key);
  assign free           = ent.valid && !ent.pin;
  assign hit_before_out = hit_before_in | hit;
  assign free_after_out = free_after_in | free;
  assign victim         = free && !free_after_in;

  always_comb begin
    case (cmd.op)
      OP_PUSH:       take_left = 1'b1;
      OP_EVICT_PUSH: take_left = free_after_in | free;
      OP_MOVE:       take_left = !hit_before_in;
      default:       take_left = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.pin   <= 1'b0;
    end else if (take_left) begin
      ent <= left;
    end else if (cmd.op == OP_UNPIN && hit) begin
      ent.pin <= 1'b0;
    end
  end

endmodule

@@ sv/lpp_ctrl.sv @@
// Request sequencer for the LRU page pool: id counter, residency count, capacity,
// decision logic and the response register. Uses lpp_pkg and the channel interfaces.
module lpp_ctrl #(
  parameter int CAP_TOP  = 16,
  parameter int ID_LIMIT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  lpp_req_if.sink           req,
  lpp_rsp_if.source         rsp,
  input  lpp_pkg::summary_t sum,
  output lpp_pkg::cmd_t     cmd
);
  import lpp_pkg::*;

  localparam logic [4:0] CapTop  = 5'(CAP_TOP);
  localparam logic [8:0] IdLimit = 9'(ID_LIMIT);

  state_t     state, state_next;
  logic [1:0] func;
  logic [7:0] pid;
  logic [8:0] next_id;
  logic [4:0] count;
  logic [4:0] capacity;
  op_t        op_r;
  logic [7:0] new_id_r;
  logic [1:0] res_status;
  logic [7:0] res_assigned;
  logic       res_load;
  logic       res_ev;
  logic [7:0] res_ev_page;
  logic       out_free;
  logic       apply;

  logic [5:0] grown_raw;
  logic [4:0] grown;
  logic       room_ok;
  logic       room_inc;
  logic       room_ev;
  op_t        room_op;
  logic [4:0] room_cap;

  op_t        d_op;
  logic [1:0] d_status;
  logic [7:0] d_assigned;
  logic       d_load;
  logic       d_ev;
  logic [7:0] d_ev_page;
  logic [4:0] d_cap;
  logic [4:0] d_count;
  logic [8:0] d_next_id;
  logic [7:0] d_new_id;
  logic       id_ok;
  logic [4:0] cfg_cap;

  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_APPLY;
      ST_APPLY: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    apply     = (state == ST_APPLY) && out_free;
    cmd.op    = apply ? op_r : OP_NONE;
    cmd.key   = pid;
    cmd.id    = new_id_r;
  end

  always_comb begin
    if (cfg_wdata < CAP_FLOOR) begin
      cfg_cap = CAP_FLOOR;
    end else if (cfg_wdata > CapTop) begin
      cfg_cap = CapTop;
    end else begin
      cfg_cap = cfg_wdata;
    end
  end

  always_comb begin
    grown_raw = {1'b0, capacity} + {2'b00, capacity[4:1]};
    grown     = (grown_raw > {1'b0, CapTop}) ? CapTop : grown_raw[4:0];
    room_ok   = 1'b0;
    room_inc  = 1'b0;
    room_ev   = 1'b0;
    room_op   = OP_NONE;
    room_cap  = capacity;
    if (count < capacity) begin
      room_ok  = 1'b1;
      room_inc = 1'b1;
      room_op  = OP_PUSH;
    end else if (sum.any_free) begin
      room_ok = 1'b1;
      room_ev = 1'b1;
      room_op = OP_EVICT_PUSH;
    end else if (capacity < CapTop) begin
      room_cap = grown;
      if (count < grown) begin
        room_ok  = 1'b1;
        room_inc = 1'b1;
        room_op  = OP_PUSH;
      end
    end
  end

  always_comb begin
    id_ok      = {1'b0, pid} < next_id;
    d_op       = OP_NONE;
    d_status   = STS_OK;
    d_assigned = pid;
    d_load     = 1'b0;
    d_ev       = 1'b0;
    d_ev_page  = 8'd0;
    d_cap      = capacity;
    d_count    = count;
    d_next_id  = next_id;
    d_new_id   = pid;
    case (func)
      FUNC_NEW: begin
        if (next_id >= IdLimit) begin
          d_status = STS_BAD_ID;
        end else begin
          d_cap = room_cap;
          if (!room_ok) begin
            d_status = STS_NO_FRAME;
          end else begin
            d_op       = room_op;
            d_assigned = next_id[7:0];
            d_new_id   = next_id[7:0];
            d_ev       = room_ev;
            d_ev_page  = room_ev ? sum.victim_id : 8'd0;
            d_count    = count + {4'd0, room_inc};
            d_next_id  = next_id + 9'd1;
          end
        end
      end
      FUNC_GET: begin
        if (!id_ok) begin
          d_status = STS_BAD_ID;
        end else if (sum.any_hit) begin
          d_op = OP_MOVE;
        end else begin
          d_cap = room_cap;
          if (!room_ok) begin
            d_status = STS_NO_FRAME;
          end else begin
            d_op      = room_op;
            d_load    = 1'b1;
            d_ev      = room_ev;
            d_ev_page = room_ev ? sum.victim_id : 8'd0;
            d_count   = count + {4'd0, room_inc};
          end
        end
      end
      FUNC_REL: begin
        if (!id_ok) begin
          d_status = STS_BAD_ID;
        end else if (!sum.hit_pin) begin
          d_status = STS_UNPINNED;
        end else begin
          d_op = OP_UNPIN;
        end
      end
      default: d_status = STS_BAD_ID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_id   <= 9'd0;
      count     <= 5'd0;
      capacity  <= CAP_FLOOR;
      op_r      <= OP_NONE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOOK) begin
        op_r         <= d_op;
        new_id_r     <= d_new_id;
        res_status   <= d_status;
        res_assigned <= d_assigned;
        res_load     <= d_load;
        res_ev       <= d_ev;
        res_ev_page  <= d_ev_page;
        capacity     <= d_cap;
        count        <= d_count;
        next_id      <= d_next_id;
      end
      if (cfg_we) begin
        capacity <= cfg_cap;
      end
      if (apply) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func <= req.func;
      pid  <= req.page_id;
    end
    if (apply) begin
      rsp.status        <= res_status;
      rsp.assigned_page <= res_assigned;
      rsp.load_needed   <= res_load;
      rsp.evict_valid   <= res_ev;
      rsp.evicted_page  <= res_ev_page;
      rsp.capacity_now  <= capacity;
    end
  end

endmodule

@@ sv/lru_page_pool_with_pinning_core.sv @@
// LRU page pool with pinning: a row of recency cells, front at cell 0, driven by
// a request sequencer. Uses lpp_pkg, the channel interfaces, lpp_cell and lpp_ctrl.
//
// Each request word is accepted, the cells are searched for the page and the eldest
// unpinned page in the LOOK state, and the row, or its front up to the hit or victim
// cell, shifts or unpins in the APPLY state; a new word is accepted in the cycle after
// that. The response word sits in an output register, so the next request is accepted
// while it waits; only the update step holds when the previous response has not been
// taken. The row has min(FRAMES,16) cells, since capacity never exceeds sixteen. Pin and
// residency flags live in the cells, as only resident pages can be pinned.
module lru_page_pool_with_pinning_core #(
  parameter int MAX_PAGES = 256,
  parameter int FRAMES    = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  lpp_req_if.sink    req,
  lpp_rsp_if.source  rsp
);
  import lpp_pkg::*;

  localparam int Cells   = (FRAMES < 16) ? FRAMES : 16;
  localparam int IdLimit = (MAX_PAGES < 256) ? MAX_PAGES : 256;

  cmd_t           cmd;
  summary_t       sum;
  entry_t         head;
  entry_t         ents [Cells];
  logic [Cells:0] hit_chain;
  logic [Cells:0] free_chain;
  logic [Cells-1:0] hits;
  logic [Cells-1:0] victims;

  assign head          = '{id: cmd.id, valid: 1'b1, pin: 1'b1};
  assign hit_chain[0]  = 1'b0;
  assign free_chain[Cells] = 1'b0;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    lpp_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .left           ((i == 0) ? head : ents[(i == 0) ? 0 : i - 1]),
      .ent            (ents[i]),
      .hit_before_in  (hit_chain[i]),
      .hit_before_out (hit_chain[i+1]),
      .free_after_in  (free_chain[i+1]),
      .free_after_out (free_chain[i]),
      .hit            (hits[i]),
      .victim         (victims[i])
    );
  end

  always_comb begin
    sum.any_hit   = hit_chain[Cells];
    sum.any_free  = free_chain[0];
    sum.hit_pin   = 1'b0;
    sum.victim_id = 8'd0;
    for (int i = 0; i < Cells; i++) begin
      sum.hit_pin   = sum.hit_pin | (hits[i] & ents[i].pin);
      sum.victim_id = sum.victim_id | (victims[i] ? ents[i].id : 8'd0);
    end
  end

  lpp_ctrl #(
    .CAP_TOP  (Cells),
    .ID_LIMIT (IdLimit)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .sum       (sum),
    .cmd       (cmd)
  );

endmodule

@@ sv/lpp_chk.sv @@
// Port-level checks for the LRU page pool, bound to the top level.
// Uses lpp_pkg for the status codes; sees only the response channel ports.
module lpp_chk (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] status,
  input logic       load_needed,
  input logic       evict_valid,
  input logic [7:0] evicted_page,
  input logic [4:0] capacity_now
);
  import lpp_pkg::*;

  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (capacity_now >= CAP_FLOOR) && (capacity_now <= 5'd16))
    else $error("capacity out of range");

  a_frame_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (evict_valid || load_needed) |-> status == STS_OK)
    else $error("eviction or load on a failed request");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evict_valid |-> evicted_page == 8'd0)
    else $error("evicted page set without eviction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(capacity_now))
    else $error("response word changed while stalled");

endmodule

bind lru_page_pool_with_pinning_core lpp_chk u_lpp_chk (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .load_needed  (rsp.load_needed),
  .evict_valid  (rsp.evict_valid),
  .evicted_page (rsp.evicted_page),
  .capacity_now (rsp.capacity_now)
);
